FILE: rtl/pcc_pkg.sv
// ----------------------------------------------------------------------------
// Pedestrian crossing controller package
// Shared types and constants for the crossing sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package pcc_pkg;

    localparam int unsigned SubTickW = 6;
    localparam int unsigned SecW     = 4;
    localparam int unsigned CfgW     = 4;
    localparam int unsigned CfgIdxW  = 2;

    localparam logic [SubTickW-1:0] TogglePointA = 6'd30;
    localparam logic [SubTickW-1:0] TogglePointB = 6'd60;
    localparam logic [SecW-1:0]     SecMax       = 4'd15;

    // Lamp bit positions
    localparam int unsigned LampVr = 0;
    localparam int unsigned LampVg = 1;
    localparam int unsigned LampWr = 2;
    localparam int unsigned LampWg = 3;
    localparam logic [3:0]  LampsIdle = 4'b0110;

    localparam logic [CfgW-1:0] WalkSecReset  = 4'd10;
    localparam logic [CfgW-1:0] BlinkSecReset = 4'd3;
    localparam logic [CfgW-1:0] ClearSecReset = 4'd1;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_WALK_SECONDS  = 2'd0,
        CFG_BLINK_SECONDS = 2'd1,
        CFG_CLEAR_SECONDS = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_VEH_BLINK  = 3'd1,
        PH_STOP       = 3'd2,
        PH_WALK       = 3'd3,
        PH_WALK_BLINK = 3'd4,
        PH_CLEAR      = 3'd5
    } phase_t;

    typedef struct packed {
        logic tick;
        logic button;
    } in_beat_t;

    typedef struct packed {
        logic       vehicle_red;
        logic       vehicle_green;
        logic       walk_red;
        logic       walk_green;
        logic [2:0] phase;
    } out_beat_t;

    typedef struct packed {
        logic [CfgW-1:0] walk_seconds;
        logic [CfgW-1:0] blink_seconds;
        logic [CfgW-1:0] clear_seconds;
    } cfg_t;

    typedef struct packed {
        phase_t              phase;
        logic [SubTickW-1:0] sub_tick;
        logic [SecW-1:0]     seconds;
        logic                request;
        logic [3:0]          lamps;
    } seq_state_t;

endpackage : pcc_pkg

`default_nettype wire

FILE: rtl/pcc_step.sv
// ----------------------------------------------------------------------------
// Pedestrian crossing step logic
// Next sequencer state for one beat of tick and button.
// ----------------------------------------------------------------------------
`default_nettype none

module pcc_step
    import pcc_pkg::*;
#(
    parameter int unsigned SUB_TICKS = 64
) (
    input  seq_state_t cur,
    input  in_beat_t   beat,
    input  cfg_t       cfg,
    output seq_state_t nxt
);

    localparam logic [SubTickW-1:0] SubTickLast = SubTickW'(SUB_TICKS - 1);

    seq_state_t t;
    logic       at_tp_cur;
    logic       at_tp_new;

    assign at_tp_cur = (cur.sub_tick == TogglePointA) || (cur.sub_tick == TogglePointB);
    assign at_tp_new = (t.sub_tick == TogglePointA) || (t.sub_tick == TogglePointB);

    // Latch the press and handle the tick first.
    always_comb begin
        t = cur;
        if (beat.button && cur.phase == PH_IDLE) begin
            t.request = 1'b1;
        end
        if (beat.tick) begin
            if (at_tp_cur && cur.phase == PH_VEH_BLINK) begin
                t.lamps[LampVg] = ~cur.lamps[LampVg];
            end else if (at_tp_cur && cur.phase == PH_WALK_BLINK) begin
                t.lamps[LampWg] = ~cur.lamps[LampWg];
            end
            if (cur.sub_tick >= SubTickLast) begin
                t.sub_tick = '0;
                if (cur.seconds != SecMax) begin
                    t.seconds = cur.seconds + 1'b1;
                end
            end else begin
                t.sub_tick = cur.sub_tick + 1'b1;
            end
        end
    end

    // At most one phase change per beat.
    always_comb begin
        nxt = t;
        unique case (cur.phase)
            PH_IDLE: begin
                nxt.lamps = LampsIdle;
                if (t.request) begin
                    nxt.sub_tick = '0;
                    nxt.seconds  = '0;
                    nxt.phase    = PH_VEH_BLINK;
                end
            end
            PH_VEH_BLINK: begin
                if (t.seconds >= cfg.blink_seconds && at_tp_new) begin
                    nxt.sub_tick       = '0;
                    nxt.seconds        = '0;
                    nxt.lamps[LampVg]  = 1'b0;
                    nxt.lamps[LampVr]  = 1'b1;
                    nxt.phase          = PH_STOP;
                end
            end
            PH_STOP: begin
                if (t.seconds >= cfg.clear_seconds) begin
                    nxt.sub_tick       = '0;
                    nxt.seconds        = '0;
                    nxt.lamps[LampWr]  = 1'b0;
                    nxt.lamps[LampWg]  = 1'b1;
                    nxt.phase          = PH_WALK;
                end
            end
            PH_WALK: begin
                if (t.seconds >= cfg.walk_seconds) begin
                    nxt.sub_tick = '0;
                    nxt.seconds  = '0;
                    nxt.phase    = PH_WALK_BLINK;
                end
            end
            PH_WALK_BLINK: begin
                if (t.seconds >= cfg.blink_seconds && at_tp_new) begin
                    nxt.sub_tick       = '0;
                    nxt.seconds        = '0;
                    nxt.lamps[LampWg]  = 1'b0;
                    nxt.lamps[LampWr]  = 1'b1;
                    nxt.phase          = PH_CLEAR;
                end
            end
            PH_CLEAR: begin
                if (t.seconds >= cfg.clear_seconds) begin
                    nxt.sub_tick = '0;
                    nxt.seconds  = '0;
                    nxt.request  = 1'b0;
                    nxt.lamps    = LampsIdle;
                    nxt.phase    = PH_IDLE;
                end
            end
            default: begin
                nxt.lamps = LampsIdle;
                nxt.phase = PH_IDLE;
            end
        endcase
    end

endmodule : pcc_step

`default_nettype wire

FILE: rtl/pcc_out_buf.sv
// ----------------------------------------------------------------------------
// Pedestrian crossing result buffer
// Two-entry output stage: result register plus skid register.
// ----------------------------------------------------------------------------
`default_nettype none

module pcc_out_buf
    import pcc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  out_beat_t push_data,
    output logic      space,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    logic      out_valid_reg;
    logic      skid_valid_reg;
    out_beat_t out_reg;
    out_beat_t skid_reg;
    logic      pop;

    assign pop     = out_valid_reg && m_ready;
    assign space   = !skid_valid_reg;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                out_reg        <= skid_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (!out_valid_reg || pop) begin
                out_reg       <= push_data;
                out_valid_reg <= 1'b1;
            end else begin
                skid_reg       <= push_data;
                skid_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            out_valid_reg <= 1'b0;
        end
    end

endmodule : pcc_out_buf

`default_nettype wire

FILE: rtl/pedestrian_crossing_controller_core.sv
// ----------------------------------------------------------------------------
// Pedestrian crossing controller core
// Push-button crossing sequencer driven by timer ticks and button beats.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake         Payload
//  s_        in         s_valid/s_ready   tick, button
//  m_        out        m_valid/m_ready   lamps (4) and phase
//  cfg_      in         cfg_wr_en         walk, blink, clear seconds
//
//  Each accepted beat's result is registered in the output stage and shown
//  on m_; a beat can be accepted every cycle while s_ready is high. A single
//  next-state stage lies between the sequencer registers and the result
//  register. A two-entry output stage lets the input keep flowing while one
//  result waits; s_ready falls only when both entries are full. Reset is
//  synchronous on aresetn low and restores idle lamps and default timings.
// ----------------------------------------------------------------------------
`default_nettype none

module pedestrian_crossing_controller_core
    import pcc_pkg::*;
#(
    parameter int unsigned SUB_TICKS = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_beat_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_beat_t            m_data,
    input  logic                 cfg_wr_en,
    input  logic [CfgIdxW-1:0]   cfg_index,
    input  logic [CfgW-1:0]      cfg_wdata
);

    cfg_t       cfg_reg;
    seq_state_t state_reg;
    seq_state_t state_next;
    out_beat_t  result;
    logic       accept;

    assign accept = s_valid && s_ready;

    // Configuration registers; writes to an unused index are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.walk_seconds  <= WalkSecReset;
            cfg_reg.blink_seconds <= BlinkSecReset;
            cfg_reg.clear_seconds <= ClearSecReset;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_WALK_SECONDS:  cfg_reg.walk_seconds  <= cfg_wdata;
                CFG_BLINK_SECONDS: cfg_reg.blink_seconds <= cfg_wdata;
                CFG_CLEAR_SECONDS: cfg_reg.clear_seconds <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // The sequencer state moves on only when a beat is accepted.
    pcc_step #(
        .SUB_TICKS(SUB_TICKS)
    ) u_step (
        .cur  (state_reg),
        .beat (s_data),
        .cfg  (cfg_reg),
        .nxt  (state_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase    <= PH_IDLE;
            state_reg.sub_tick <= '0;
            state_reg.seconds  <= '0;
            state_reg.request  <= 1'b0;
            state_reg.lamps    <= LampsIdle;
        end else if (accept) begin
            state_reg <= state_next;
        end
    end

    // The result of a beat is the lamps and phase after that beat.
    assign result.vehicle_red   = state_next.lamps[LampVr];
    assign result.vehicle_green = state_next.lamps[LampVg];
    assign result.walk_red      = state_next.lamps[LampWr];
    assign result.walk_green    = state_next.lamps[LampWg];
    assign result.phase         = state_next.phase;

    pcc_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept),
        .push_data (result),
        .space     (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // Idle always shows vehicle green and pedestrian red.
    a_idle_lamps: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.phase == PH_IDLE |-> state_reg.lamps == LampsIdle)
        else $error("idle phase with wrong lamps");

    // Vehicles and pedestrians never both see green.
    a_no_dual_green: assert property (@(posedge aclk) disable iff (!aresetn)
        !(state_reg.lamps[LampVg] && state_reg.lamps[LampWg]))
        else $error("vehicle and pedestrian green together");

    // An accepted beat always leaves a result in the output stage.
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("accepted beat produced no result");

    // The input stalls only when a result is waiting to be taken.
    a_stall_reason: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !$past(m_ready && m_valid && !s_ready))
        else $error("input stalled without a pending result");

endmodule : pedestrian_crossing_controller_core

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Pedestrian crossing controller core testbench
// Drives random tick and press beats through several timing settings, with
// random gaps and back-pressure, and checks every result beat against a
// cycle-free model of the crossing sequence.
// ----------------------------------------------------------------------------

module tb;
    import pcc_pkg::*;

    // The design runs at its default sub-tick period; the model follows it.
    localparam int unsigned SubTicks = 64;
    localparam logic [SubTickW-1:0] SubTickLast = SubTickW'(SubTicks - 1);

    // Index 3 has no register behind it; a write there must change nothing.
    localparam logic [CfgIdxW-1:0] CfgIdxSpare = 2'd3;

    // Cycles with no beat accepted and no result taken before the run is declared hung.
    localparam int QuietLimit = 2000;

    // Clock and reset.
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    // Block ports. Every input has a known value from time zero.
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    in_beat_t             s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    out_beat_t            m_data;
    logic                 cfg_wr_en = 1'b0;
    logic [CfgIdxW-1:0]   cfg_index = '0;
    logic [CfgW-1:0]      cfg_wdata = '0;

    // Beats waiting to be offered, and lamp states waiting to be seen.
    in_beat_t  pending_beats[$];
    out_beat_t lamp_forecast_q[$];

    // Set at a rising edge when the beat on s_ was taken, read by the driver.
    logic beat_taken = 1'b0;

    int fail_count   = 0;
    int quiet_cycles = 0;

    // Idling patterns as percentages: sender gap, receiver stall.
    int idle_pattern[4][2] = '{'{0, 0}, '{72, 0}, '{0, 72}, '{37, 37}};
    int pattern_sel   = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;

    // Shadow of the sequencer: timing registers and state.
    logic [CfgW-1:0]     timing_walk;
    logic [CfgW-1:0]     timing_blink;
    logic [CfgW-1:0]     timing_clear;
    phase_t              seq_phase;
    logic [SubTickW-1:0] seq_sub_tick;
    logic [SecW-1:0]     seq_seconds;
    logic                seq_request;
    logic [3:0]          seq_lamps;

    pedestrian_crossing_controller_core #(
        .SUB_TICKS (SubTicks)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Sequence model
    // ------------------------------------------------------------------------

    // Advances the shadow sequencer by one input beat and returns the lamps
    // and phase that the block should show afterwards. Within a beat the
    // press is latched first, then the tick toggles a blinking lamp and
    // advances the counters, and only then is at most one phase change made.
    function automatic out_beat_t advance_crossing(input in_beat_t beat);
        out_beat_t lamps_out;
        logic      at_toggle;

        // A press only counts while the crossing is idle; otherwise it is lost.
        if (beat.button && seq_phase == PH_IDLE) begin
            seq_request = 1'b1;
        end

        if (beat.tick) begin
            // The blink toggle looks at the sub-tick count before it moves on.
            if (seq_sub_tick == TogglePointA || seq_sub_tick == TogglePointB) begin
                if (seq_phase == PH_VEH_BLINK) begin
                    seq_lamps[LampVg] = ~seq_lamps[LampVg];
                end else if (seq_phase == PH_WALK_BLINK) begin
                    seq_lamps[LampWg] = ~seq_lamps[LampWg];
                end
            end
            if (seq_sub_tick >= SubTickLast) begin
                seq_sub_tick = '0;
                // The seconds count sticks at its ceiling rather than wrapping.
                if (seq_seconds != SecMax) begin
                    seq_seconds = seq_seconds + 1'b1;
                end
            end else begin
                seq_sub_tick = seq_sub_tick + 1'b1;
            end
        end

        // The blink phases end only on a toggle point, judged after the count.
        at_toggle = (seq_sub_tick == TogglePointA || seq_sub_tick == TogglePointB);

        case (seq_phase)
            PH_IDLE: begin
                seq_lamps = LampsIdle;
                // A tick in the same beat as the press is wiped by the restart.
                if (seq_request) begin
                    seq_sub_tick = '0;
                    seq_seconds  = '0;
                    seq_phase    = PH_VEH_BLINK;
                end
            end
            PH_VEH_BLINK: begin
                if (seq_seconds >= timing_blink && at_toggle) begin
                    seq_sub_tick      = '0;
                    seq_seconds       = '0;
                    seq_lamps[LampVg] = 1'b0;
                    seq_lamps[LampVr] = 1'b1;
                    seq_phase         = PH_STOP;
                end
            end
            PH_STOP: begin
                // With a zero setting this holds on the very next beat.
                if (seq_seconds >= timing_clear) begin
                    seq_sub_tick      = '0;
                    seq_seconds       = '0;
                    seq_lamps[LampWr] = 1'b0;
                    seq_lamps[LampWg] = 1'b1;
                    seq_phase         = PH_WALK;
                end
            end
            PH_WALK: begin
                if (seq_seconds >= timing_walk) begin
                    seq_sub_tick = '0;
                    seq_seconds  = '0;
                    seq_phase    = PH_WALK_BLINK;
                end
            end
            PH_WALK_BLINK: begin
                if (seq_seconds >= timing_blink && at_toggle) begin
                    seq_sub_tick      = '0;
                    seq_seconds       = '0;
                    seq_lamps[LampWg] = 1'b0;
                    seq_lamps[LampWr] = 1'b1;
                    seq_phase         = PH_CLEAR;
                end
            end
            PH_CLEAR: begin
                if (seq_seconds >= timing_clear) begin
                    seq_sub_tick = '0;
                    seq_seconds  = '0;
                    seq_request  = 1'b0;
                    seq_phase    = PH_IDLE;
                    seq_lamps    = LampsIdle;
                end
            end
            default: begin
                // Unused phase codes fall back to idle.
                seq_phase = PH_IDLE;
                seq_lamps = LampsIdle;
            end
        endcase

        lamps_out.vehicle_red   = seq_lamps[LampVr];
        lamps_out.vehicle_green = seq_lamps[LampVg];
        lamps_out.walk_red      = seq_lamps[LampWr];
        lamps_out.walk_green    = seq_lamps[LampWg];
        lamps_out.phase         = seq_phase;
        return lamps_out;
    endfunction

    // Four-state compare, so that an unknown bit on the output is caught.
    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            fail_count++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver: all inputs change on the falling edge. A beat already on s_ is
    // held until it has been taken; only then is the next one, or a gap,
    // chosen.
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            m_ready <= 1'b0;
        end else begin
            if (!s_valid || beat_taken) begin
                if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_data  <= pending_beats.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: samples on the rising edge, before the block's registers move.
    // Register writes, result checks and new forecasts are all handled here
    // so that the shadow state changes in step with the block.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            beat_taken   <= 1'b0;
            quiet_cycles = 0;
            timing_walk  = WalkSecReset;
            timing_blink = BlinkSecReset;
            timing_clear = ClearSecReset;
            seq_phase    = PH_IDLE;
            seq_sub_tick = '0;
            seq_seconds  = '0;
            seq_request  = 1'b0;
            seq_lamps    = LampsIdle;
            lamp_forecast_q.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_WALK_SECONDS:  timing_walk  = cfg_wdata;
                    CFG_BLINK_SECONDS: timing_blink = cfg_wdata;
                    CFG_CLEAR_SECONDS: timing_clear = cfg_wdata;
                    default: ;
                endcase
            end

            // A result can never belong to a beat taken on the same edge, so
            // it is checked before any new forecast is queued.
            if (m_valid && m_ready) begin
                if (lamp_forecast_q.size() == 0) begin
                    $error("result beat arrived with no result expected");
                    fail_count++;
                end else begin
                    out_beat_t want;
                    want = lamp_forecast_q.pop_front();
                    check_field("vehicle_red", want.vehicle_red, m_data.vehicle_red);
                    check_field("vehicle_green", want.vehicle_green, m_data.vehicle_green);
                    check_field("walk_red", want.walk_red, m_data.walk_red);
                    check_field("walk_green", want.walk_green, m_data.walk_green);
                    check_field("phase", want.phase, m_data.phase);
                end
            end

            if (s_valid && s_ready) begin
                lamp_forecast_q.push_back(advance_crossing(s_data));
            end
            beat_taken <= s_valid && s_ready;

            // Watchdog: a long spell with no beat moving either way means a hang.
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QuietLimit) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    // Holds the sender back until everything offered has come back checked.
    task automatic drain_results();
        while (pending_beats.size() != 0 || s_valid || lamp_forecast_q.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic queue_beats(input int count, input int tick_pct, input int press_pct);
        in_beat_t beat;
        repeat (count) begin
            beat.tick   = ($urandom_range(99) < tick_pct);
            beat.button = ($urandom_range(99) < press_pct);
            pending_beats.push_back(beat);
        end
    endtask

    // One timing setting: wait for the block to fall quiet, reprogram all
    // three registers, move to the next idling pattern and queue the beats.
    task automatic run_phase(input logic [CfgW-1:0] walk, blink, clear,
                             input int count, tick_pct, press_pct);
        drain_results();
        write_reg(CFG_WALK_SECONDS, walk);
        write_reg(CFG_BLINK_SECONDS, blink);
        write_reg(CFG_CLEAR_SECONDS, clear);
        send_idle_pct = idle_pattern[pattern_sel][0];
        stall_pct     = idle_pattern[pattern_sel][1];
        pattern_sel   = (pattern_sel + 1) % 4;
        queue_beats(count, tick_pct, press_pct);
    endtask

    initial begin
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed beats at the reset timings: an empty beat, a bare tick in
        // idle, a tick and a press together in idle (which starts the
        // sequence), then presses that arrive once it is already running.
        pending_beats.push_back(in_beat_t'{tick: 1'b0, button: 1'b0});
        pending_beats.push_back(in_beat_t'{tick: 1'b1, button: 1'b0});
        pending_beats.push_back(in_beat_t'{tick: 1'b1, button: 1'b1});
        pending_beats.push_back(in_beat_t'{tick: 1'b0, button: 1'b1});
        pending_beats.push_back(in_beat_t'{tick: 1'b1, button: 1'b1});
        pending_beats.push_back(in_beat_t'{tick: 1'b0, button: 1'b0});
        pending_beats.push_back(in_beat_t'{tick: 1'b1, button: 1'b0});

        // All-zero timings: every timed phase ends as soon as it may, so
        // whole sequences run back to back.
        run_phase(4'd0, 4'd0, 4'd0, 100, 95, 12);

        // Short timings, with a pause in the middle of the stream so that the
        // sender waits for every result while the sequence is part way through.
        run_phase(4'd1, 4'd1, 4'd1, 200, 95, 10);
        drain_results();
        queue_beats(200, 95, 10);

        // A write to the spare index must leave the timings alone.
        drain_results();
        write_reg(CfgIdxSpare, 4'hF);
        run_phase(4'd2, 4'd1, 4'd3, 120, 90, 8);

        run_phase(4'd1, 4'd0, 4'd2, 120, 80, 15);

        // Largest timings: ticking every beat, the run stays inside the long
        // vehicle blink and sees the green lamp toggle many times.
        run_phase(4'd15, 4'd15, 4'd15, 200, 100, 5);

        drain_results();
        repeat (10) @(posedge aclk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
